// File: hdl/rtd_pkg.sv
package rtd_pkg;

  localparam int unsigned TEMP_W = 14;
  localparam int unsigned RES_W = 32;
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 24;
  localparam int unsigned ROM_DEPTH = 230;
  localparam int unsigned ROM_IDX_W = 8;

  localparam logic signed [TEMP_W-1:0] BELOW_TENTHS = -14'sd1000;
  localparam logic signed [TEMP_W-1:0] ABOVE_TENTHS = 14'sd5000;

  localparam logic [NUM_W-1:0] NUM_SCALE = 48'd10000000;
  localparam logic [DEN_W-1:0] NUM_OFFSET = 24'd1163151;
  localparam logic [DEN_W-1:0] DEN_OFFSET = 24'd14181849;
  localparam logic [DEN_W-1:0] ADC_SCALE = 24'd1000;

  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [RES_W-1:0] res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_ITP_DIV,
    ST_DONE
  } back_state_e;

  localparam logic [RES_W-1:0] PT_MOHM [ROM_DEPTH] = '{
    803063,807033,811003,814970,818937,822902,826865,830828,834789,838748,
    842707,846663,850619,854573,858526,862478,866428,870377,874325,878271,
    882217,886160,890103,894044,897985,901923,905861,909797,913732,917666,
    921599,925530,929461,933390,937317,941244,945169,949093,953016,956938,
    960859,964778,968696,972613,976529,980444,984358,988270,992181,996091,
    1000000,1003908,1007814,1011720,1015624,1019527,1023429,1027330,1031229,1035128,
    1039025,1042921,1046816,1050710,1054603,1058495,1062385,1066274,1070162,1074049,
    1077935,1081820,1085703,1089585,1093467,1097347,1101225,1105103,1108980,1112855,
    1116729,1120602,1124474,1128345,1132215,1136083,1139950,1143817,1147681,1151545,
    1155408,1159270,1163130,1166989,1170847,1174704,1178560,1182414,1186268,1190120,
    1193971,1197821,1201670,1205518,1209364,1213210,1217054,1220897,1224739,1228579,
    1232419,1236257,1240095,1243931,1247766,1251600,1255432,1259264,1263094,1266923,
    1270751,1274578,1278404,1282228,1286052,1289874,1293695,1297515,1301334,1305152,
    1308968,1312783,1316597,1320411,1324222,1328033,1331843,1335651,1339458,1343264,
    1347069,1350873,1354676,1358477,1362277,1366077,1369875,1373671,1377467,1381262,
    1385055,1388847,1392638,1396428,1400217,1404005,1407791,1411576,1415360,1419143,
    1422925,1426706,1430485,1434264,1438041,1441817,1445592,1449366,1453138,1456910,
    1460680,1464449,1468217,1471984,1475750,1479514,1483277,1487040,1490801,1494561,
    1498319,1502077,1505833,1509589,1513343,1517096,1520847,1524598,1528347,1532096,
    1535843,1539589,1543334,1547078,1550820,1554562,1558302,1562041,1565779,1569516,
    1573251,1576986,1580719,1584451,1588182,1591912,1595641,1599368,1603095,1606820,
    1610544,1614267,1617989,1621709,1625429,1629147,1632864,1636580,1640295,1644009,
    1647721,1651433,1655143,1658852,1662560,1666267,1669972,1673677,1677380,1681082
  };

endpackage

// File: hdl/rtd_stream_if.sv
interface rtd_stream_if #(
  parameter int unsigned W = 10
);
  logic valid;
  logic ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rtd_front.sv
module rtd_front #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtd_stream_if.sink in_i,
  output logic q_valid_o,
  output logic [SAMPLE_BITS-1:0] q_data_o,
  input  logic q_ready_i
);
  // two-entry queue of changed samples
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SAMPLE_BITS-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready && (in_i.data != prev_q);
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        prev_q <= in_i.data;
        wp_q <= ~wp_q;
      end
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i.data;
  end
endmodule

// File: hdl/rtd_back.sv
module rtd_back
  import rtd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  logic [SAMPLE_BITS-1:0] q_data_i,
  output logic q_ready_o,
  rtd_stream_if.source out_o
);
  localparam int unsigned AW = SAMPLE_BITS + 10;

  back_state_e st_q, st_d;
  logic [NUM_W-1:0] rem_q;      // remainder, fed by the dividend shifting out of quo_q
  logic [NUM_W-1:0] quo_q;
  logic [NUM_W-1:0] div_q;      // divisor
  logic [5:0] cnt_q;
  logic [ROM_IDX_W-1:0] lo_q, hi_q;
  res_t r_q;
  logic signed [TEMP_W-1:0] res_q;
  logic signed [TEMP_W-1:0] out_q;
  logic out_v_q;
  logic neg_q;

  logic [AW-1:0] adc_k;
  logic [NUM_W-1:0] rem_sh, rem_n, num_w;
  logic [DEN_W+1:0] den_w;
  logic den_bad;
  logic [ROM_IDX_W-1:0] mid;
  logic [ROM_IDX_W:0] mid_sum;
  res_t d_seg, off_seg;
  logic [NUM_W-1:0] itp_num;
  logic signed [TEMP_W-1:0] base_t;
  logic [NUM_W-1:0] quo_n;
  logic rnd_up;

  assign adc_k = AW'(q_data_i) * AW'(ADC_SCALE);
  assign den_w = {2'b0, DEN_OFFSET} - (DEN_W + 2)'(adc_k);
  assign den_bad = (32'(adc_k) >= 32'(DEN_OFFSET));
  assign num_w = NUM_SCALE * (NUM_W'(NUM_OFFSET) + NUM_W'(adc_k));
  assign rem_sh = {rem_q[NUM_W-2:0], quo_q[NUM_W-1]};
  assign rem_n = (rem_sh >= div_q) ? rem_sh - div_q : rem_sh;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
  assign mid = mid_sum[ROM_IDX_W:1];
  assign d_seg = PT_MOHM[lo_q + 1'b1] - PT_MOHM[lo_q];
  assign off_seg = r_q - PT_MOHM[lo_q];
  assign itp_num = NUM_W'(off_seg) * NUM_W'(10);
  assign base_t = TEMP_W'((signed'({1'b0, lo_q}) - 9'sd50) * 10);
  assign quo_n = (quo_q << 1) | NUM_W'(rem_sh >= div_q);
  // below zero the quotient must round toward zero, not down
  assign rnd_up = base_t[TEMP_W-1] && (rem_n != '0);

  assign q_ready_o = (st_q == ST_IDLE);
  assign out_o.valid = out_v_q;
  assign out_o.data = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (q_valid_i) begin
        if (den_bad) st_d = ST_DONE;
        else st_d = ST_DIV;
      end
      ST_DIV: if (cnt_q == 6'd0) st_d = ST_SEARCH;
      ST_SEARCH: if (lo_q >= hi_q || r_q < PT_MOHM[0] || r_q > PT_MOHM[ROM_DEPTH-1])
        st_d = ST_ITP_DIV;
      ST_ITP_DIV: if (cnt_q == 6'd0) st_d = ST_DONE;
      ST_DONE: if (!out_v_q || out_o.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_DONE && (!out_v_q || out_o.ready)) out_v_q <= 1'b1;
      else if (out_v_q && out_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          rem_q <= '0;
          quo_q <= num_w;
          div_q <= NUM_W'(den_w);
          cnt_q <= 6'(NUM_W - 1);
          if (den_bad) begin
            neg_q <= 1'b0;
            res_q <= ABOVE_TENTHS;
          end else neg_q <= 1'b1;
        end
      end
      ST_DIV: begin
        rem_q <= rem_n;
        quo_q <= quo_n;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          // anything past 32 bits is far above the table
          r_q <= (|quo_n[NUM_W-1:RES_W]) ? '1 : RES_W'(quo_n);
          lo_q <= '0;
          hi_q <= ROM_IDX_W'(ROM_DEPTH - 1);
        end
      end
      ST_SEARCH: begin
        if (r_q < PT_MOHM[0]) begin
          res_q <= BELOW_TENTHS;
          neg_q <= 1'b0;
        end else if (r_q > PT_MOHM[ROM_DEPTH-1]) begin
          res_q <= ABOVE_TENTHS;
          neg_q <= 1'b0;
        end else if (lo_q >= hi_q) begin
          // exact last entry uses the final segment
          if (lo_q > ROM_IDX_W'(ROM_DEPTH - 2)) lo_q <= ROM_IDX_W'(ROM_DEPTH - 2);
          cnt_q <= 6'(NUM_W);
        end else if (PT_MOHM[mid] <= r_q) lo_q <= mid;
        else hi_q <= mid - 1'b1;
      end
      ST_ITP_DIV: begin
        if (cnt_q == 6'(NUM_W) && neg_q) begin
          rem_q <= '0;
          quo_q <= itp_num;
          div_q <= NUM_W'(d_seg);
          cnt_q <= cnt_q - 6'd1;
        end else if (neg_q) begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) res_q <= base_t + TEMP_W'(quo_n) + TEMP_W'(rnd_up);
        end else cnt_q <= 6'd0;
      end
      ST_DONE: if (!out_v_q || out_o.ready) out_q <= res_q;
      default: ;
    endcase
  end
endmodule

// File: hdl/rtd_adc_to_temperature_unit.sv
// flow: a changed sample runs through the resistance division, the table search and
// the interpolation division, and a reading outside the table skips the last; the two
// bit-serial 48-bit dividers sit on either side of an 8-step table search
// the back part takes no new sample until the last result is in its output register;
// unchanged samples are dropped by the front part, and a two-item queue lets the input run ahead until it fills
// reset: asynchronous active low; previous sample clears to 0, queue empties
module rtd_adc_to_temperature_unit
  import rtd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtd_stream_if.sink adc_i,
  rtd_stream_if.source temp_o
);
  logic q_valid, q_ready;
  logic [SAMPLE_BITS-1:0] q_data;

  rtd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .in_i(adc_i),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_ready_i(q_ready)
  );

  rtd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_ready_o(q_ready),
    .out_o(temp_o)
  );
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rtd_pkg::*;

  logic clk_i;
  logic rst_ni;

  rtd_stream_if #(.W(10)) adc_if ();
  rtd_stream_if #(.W(TEMP_W)) temp_if ();

  rtd_adc_to_temperature_unit #(.SAMPLE_BITS(10)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adc_i (adc_if),
    .temp_o(temp_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  temp_t       temp_expected_q[$];
  logic [9:0]  last_sample;
  logic        idle_en;
  int unsigned hold_req;
  int unsigned hold_left;
  logic        hold_off;
  int unsigned n_err;
  int unsigned n_samples;
  int unsigned n_temps;
  int unsigned n_checked;

  // tenths of a degree for one converter reading
  function automatic temp_t temp_from_adc(logic [9:0] adc);
    longint unsigned num;
    longint unsigned res;
    longint lo;
    longint hi;
    longint mid;
    longint d;
    longint off;
    longint t;
    num = 64'd10000000 * (64'd1163151 + 64'd1000 * adc);
    res = num / (64'd14181849 - 64'd1000 * adc);
    if (res < PT_MOHM[0]) begin
      t = -1000;
    end else if (res > PT_MOHM[ROM_DEPTH-1]) begin
      t = 5000;
    end else begin
      lo = 0;
      hi = ROM_DEPTH - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (PT_MOHM[mid] <= res) lo = mid;
        else hi = mid - 1;
      end
      // exact hit on the top entry folds into the last segment
      if (lo > ROM_DEPTH - 2) lo = ROM_DEPTH - 2;
      d = longint'(PT_MOHM[lo+1]) - longint'(PT_MOHM[lo]);
      off = longint'(res) - longint'(PT_MOHM[lo]);
      if (d <= 0) t = (lo - 50) * 10;
      else t = ((lo - 50) * 10 * d + 10 * off) / d;
    end
    return temp_t'(t);
  endfunction

  // sender: valid stays high between back-to-back items
  task automatic send_sample(logic [9:0] v);
    while (idle_en && $urandom_range(99) < 33) begin
      adc_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    adc_if.valid <= 1'b1;
    adc_if.data <= v;
    @(posedge clk_i);
    while (!adc_if.ready) @(posedge clk_i);
    n_samples++;
    if (v != last_sample) begin
      last_sample = v;
      temp_expected_q.push_back(temp_from_adc(v));
    end
  endtask

  task automatic wait_drained();
    adc_if.valid <= 1'b0;
    @(posedge clk_i);
    while (temp_expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // hold-off counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_off <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      hold_off <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      hold_off <= 1'b0;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (temp_if.valid && temp_if.ready) begin
        n_temps++;
        if (temp_expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected temperature %0d", $signed(temp_if.data));
        end else begin
          temp_t want;
          want = temp_expected_q.pop_front();
          n_checked++;
          if (temp_if.data !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("temperature mismatch: expected %0d got %0d",
                       $signed(want), $signed(temp_if.data));
          end
        end
      end
      if (hold_off) temp_if.ready <= 1'b0;
      else if (idle_en) temp_if.ready <= ($urandom_range(99) >= 33);
      else temp_if.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    logic [9:0] vals[$] = '{10'd0, 10'd0, 10'd1, 10'd1023, 10'd1023, 10'd1022, 10'd0,
                             10'd512, 10'd511, 10'h155, 10'h2AA, 10'd1, 10'd1000,
                             10'd1023, 10'd2, 10'd300, 10'd700, 10'd700};
    idle_en = 1'b0;
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 400;
    repeat (30) send_sample(10'($urandom_range(1023)));
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    logic [9:0] v;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      // long stretch with no idling in the middle
      idle_en = !(i >= count / 3 && i < count / 2);
      pick = $urandom_range(99);
      if (pick < 20) v = last_sample;
      else if (pick < 45) v = last_sample + 10'($urandom_range(8)) - 10'd4;
      else if (pick < 55) v = $urandom_range(1) ? 10'($urandom_range(1023, 1000))
                                                : 10'($urandom_range(20));
      else v = 10'($urandom_range(1023));
      send_sample(v);
      if (i == count / 4) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    adc_if.valid = 1'b0;
    adc_if.data = '0;
    temp_if.ready = 1'b0;
    idle_en = 1'b0;
    hold_req = 0;
    last_sample = '0;
    n_err = 0;
    n_samples = 0;
    n_temps = 0;
    n_checked = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(900);
    if (temp_expected_q.size() != 0) begin
      n_err += temp_expected_q.size();
      $display("%0d temperatures never arrived", temp_expected_q.size());
    end
    $display("sent %0d adc samples, received %0d and checked %0d temperatures (%0d mismatches)",
             n_samples, n_temps, n_checked, n_err);
    $display("covered repeats, range ends, output stall and random idling");
    if (n_err == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: rtd_adc_to_temperature_unit.f
hdl/rtd_pkg.sv
hdl/rtd_stream_if.sv
hdl/rtd_front.sv
hdl/rtd_back.sv
hdl/rtd_adc_to_temperature_unit.sv
test/tb_top.sv
